// ----- hdl/wscfd_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Shared result type, result kinds and protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wscfd_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        last_of_frame;
  } result_t;

  localparam logic [3:0]  OP_BINARY = 4'h2;
  localparam logic [3:0]  OP_CLOSE  = 4'h8;
  localparam logic [3:0]  OP_PING   = 4'h9;
  localparam logic [3:0]  OP_PONG   = 4'hA;

  localparam logic [6:0]  LEN_SHORT_MAX = 7'd125;
  localparam logic [6:0]  LEN_CODE_16   = 7'd126;
  localparam logic [63:0] LEN16_MIN     = 64'd126;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

endpackage

`default_nettype wire

// ----- hdl/wscfd_if.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame decoder stream interfaces
// Byte input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wscfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface wscfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       last_of_frame;

  modport source (output valid, output kind, output payload_byte,
                  output frame_opcode, output last_of_frame, input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input frame_opcode, input last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- hdl/wscfd_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Per-byte header, length and mask parsing with payload unmasking.
// ----------------------------------------------------------------------------
`default_nettype none

module wscfd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              restart_i,
  input  wire logic [31:0]       max_payload_i,
  output logic                   res_valid_o,
  output wscfd_pkg::result_t     res_o
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  first_q, first_d;
  logic [63:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [6:0]  code_q, code_d;
  logic [31:0] key_q, key_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  idx_q, idx_d;
  logic        err_q, err_d;

  logic [3:0]  op;
  logic [6:0]  len7;
  logic        hdr_bad;
  logic [63:0] acc_next;
  logic [2:0]  cnt_next;
  logic [2:0]  need;
  logic        len_bad;
  logic        over_max;
  logic [7:0]  key_byte;
  logic        clear_all;

  assign op       = first_q[3:0];
  assign len7     = data_byte_i[6:0];
  assign acc_next = {acc_q[55:0], data_byte_i};
  assign cnt_next = cnt_q + 3'd1;
  // eight length bytes wrap the count back to zero
  assign need     = (code_q == wscfd_pkg::LEN_CODE_16) ? 3'd2 : 3'd0;
  assign len_bad  = (code_q == wscfd_pkg::LEN_CODE_16) ? (acc_next < wscfd_pkg::LEN16_MIN)
                                                       : (acc_next[63:16] == 48'd0);
  assign over_max = (acc_next[63:32] != 32'd0) || (acc_next[31:0] > max_payload_i);

  always_comb begin
    hdr_bad = !first_q[7] || (first_q[6:4] != 3'd0) || !data_byte_i[7] ||
              !((op == wscfd_pkg::OP_BINARY) || (op == wscfd_pkg::OP_CLOSE) ||
                (op == wscfd_pkg::OP_PING) || (op == wscfd_pkg::OP_PONG)) ||
              (op[3] && (len7 > wscfd_pkg::LEN_SHORT_MAX));
  end

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    first_d   = first_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    key_d     = key_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    err_d     = err_q;
    clear_all = 1'b0;
    res_valid_o = 1'b0;
    res_o = '{kind: wscfd_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
              frame_opcode: 4'd0, last_of_frame: 1'b0};

    if (accept_i) begin
      if (restart_i) begin
        clear_all = 1'b0 | 1'b1;
      end else if (!err_q) begin
        case (phase_q)
          PH_HDR0: begin
            first_d = data_byte_i;
            phase_d = PH_HDR1;
          end
          PH_HDR1: begin
            if (hdr_bad) begin
              err_d = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind = wscfd_pkg::KIND_ERROR;
            end else begin
              code_d = len7;
              acc_d  = 64'd0;
              cnt_d  = 3'd0;
              if (len7 <= wscfd_pkg::LEN_SHORT_MAX) begin
                if ({25'd0, len7} > max_payload_i) begin
                  err_d = 1'b1;
                  res_valid_o = 1'b1;
                  res_o.kind = wscfd_pkg::KIND_ERROR;
                end else begin
                  rem_d   = {25'd0, len7};
                  key_d   = 32'd0;
                  phase_d = PH_MASK;
                end
              end else begin
                phase_d = PH_EXTLEN;
              end
            end
          end
          PH_EXTLEN: begin
            acc_d = acc_next;
            cnt_d = cnt_next;
            if (cnt_next == need) begin
              if (len_bad || over_max) begin
                err_d = 1'b1;
                res_valid_o = 1'b1;
                res_o.kind = wscfd_pkg::KIND_ERROR;
              end else begin
                rem_d   = acc_next[31:0];
                cnt_d   = 3'd0;
                key_d   = 32'd0;
                phase_d = PH_MASK;
              end
            end
          end
          PH_MASK: begin
            key_d = {key_q[23:0], data_byte_i};
            cnt_d = cnt_next;
            if (cnt_next == 3'd4) begin
              cnt_d = 3'd0;
              idx_d = 2'd0;
              if (rem_q == 32'd0) begin
                phase_d = PH_HDR0;
                res_valid_o = 1'b1;
                res_o.kind = wscfd_pkg::KIND_EMPTY;
                res_o.frame_opcode = op;
                res_o.last_of_frame = 1'b1;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            idx_d = idx_q + 2'd1;
            rem_d = rem_q - 32'd1;
            if (rem_q == 32'd1) begin
              phase_d = PH_HDR0;
            end
            res_valid_o = 1'b1;
            res_o.kind = wscfd_pkg::KIND_PAYLOAD;
            res_o.payload_byte = data_byte_i ^ key_byte;
            res_o.frame_opcode = op;
            res_o.last_of_frame = (rem_q == 32'd1);
          end
          default: begin
            clear_all = 1'b1;
          end
        endcase
      end
    end

    if (clear_all) begin
      phase_d = PH_HDR0;
      first_d = 8'd0;
      acc_d   = 64'd0;
      cnt_d   = 3'd0;
      code_d  = 7'd0;
      key_d   = 32'd0;
      rem_d   = 32'd0;
      idx_d   = 2'd0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      first_q <= 8'd0;
      acc_q   <= 64'd0;
      cnt_q   <= 3'd0;
      code_q  <= 7'd0;
      key_q   <= 32'd0;
      rem_q   <= 32'd0;
      idx_q   <= 2'd0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      code_q  <= code_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/websocket_client_frame_decoder.sv -----
// Each result is registered in the output register, or in the skid register while
// the output is held. Throughput: one byte per cycle while the skid is empty; the
// parser updates all frame state in a single pass. A two-entry output stage (main
// register plus skid) keeps input ready independent of the result channel's ready.
// Reset: max payload 1048576, parser waits for a first header byte, no error latched.
// ----------------------------------------------------------------------------
// WebSocket client frame decoder
// Top level: config register, frame parser and skid-buffered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_client_frame_decoder (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  wscfd_in_if.sink     in_i,
  wscfd_out_if.source  out_o
);

  logic [31:0]        max_q;
  logic               accept;
  logic               res_valid;
  wscfd_pkg::result_t res;

  logic               ov_q, ov_d;
  logic               sv_q, sv_d;
  wscfd_pkg::result_t out_q, out_d;
  wscfd_pkg::result_t skid_q, skid_d;

  assign in_i.ready = !sv_q;
  assign accept     = in_i.valid && !sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= wscfd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  wscfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .restart_i     (in_i.restart),
    .max_payload_i (max_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_comb begin
    ov_d   = ov_q;
    sv_d   = sv_q;
    out_d  = out_q;
    skid_d = skid_q;
    if (!ov_q || out_o.ready) begin
      // advance: drain skid first, then take the fresh word
      if (sv_q) begin
        out_d = skid_q;
        ov_d  = 1'b1;
        sv_d  = 1'b0;
      end else if (res_valid) begin
        out_d = res;
        ov_d  = 1'b1;
      end else begin
        ov_d  = 1'b0;
      end
    end else if (res_valid) begin
      // hold: park the new word in the skid register
      skid_d = res;
      sv_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.payload_byte  = out_q.payload_byte;
  assign out_o.frame_opcode  = out_q.frame_opcode;
  assign out_o.last_of_frame = out_q.last_of_frame;

endmodule

`default_nettype wire

// ----- tb/tb_websocket_client_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket client frame decoder testbench
// Feeds client byte streams (well-formed frames, broken headers, noise and
// restarts) under several payload limits, tracks the parser state alongside
// the block and checks every decoded word in order against the prediction.
// ----------------------------------------------------------------------------

module tb_websocket_client_frame_decoder;

  localparam int          STALL_LIMIT = 1000;
  localparam int          HOLD_CYCLES = 80;
  localparam logic [6:0]  LEN_CODE_64 = 7'd127;

  typedef enum {FORM_SHORT, FORM_16, FORM_64} len_form_e;

  // Tracks the frame parser and holds the decoded words still to come out.
  class ws_frame_tracker;
    typedef enum logic [2:0] {ST_HEAD0, ST_HEAD1, ST_LENGTH, ST_KEY, ST_DATA} parse_e;

    parse_e                st;
    logic [7:0]            head0;
    logic [63:0]           len_acc;
    logic [2:0]            hdr_cnt;
    logic [6:0]            len_code;
    logic [31:0]           key;
    logic [63:0]           remain;
    logic [1:0]            key_pos;
    bit                    stuck;
    logic [31:0]           max_len;
    wscfd_pkg::result_t    decoded_q[$];
    int                    errors;

    function new();
      max_len = wscfd_pkg::MAX_PAYLOAD_RESET;
      errors  = 0;
      clear();
    endfunction

    function void clear();
      st       = ST_HEAD0;
      head0    = '0;
      len_acc  = '0;
      hdr_cnt  = '0;
      len_code = '0;
      key      = '0;
      remain   = '0;
      key_pos  = '0;
      stuck    = 1'b0;
    endfunction

    function void set_limit(logic [31:0] v);
      max_len = v;
    endfunction

    function bit latched();
      return stuck;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void push(wscfd_pkg::kind_e k, logic [7:0] d, logic [3:0] op, logic l);
      wscfd_pkg::result_t r;
      r.kind          = k;
      r.payload_byte  = d;
      r.frame_opcode  = op;
      r.last_of_frame = l;
      decoded_q.push_back(r);
    endfunction

    function void latch_error();
      stuck = 1'b1;
      push(wscfd_pkg::KIND_ERROR, 8'h00, 4'h0, 1'b0);
    endfunction

    function void note_word(logic [7:0] b, logic rs);
      logic [3:0] op;
      logic [6:0] len7;
      logic [2:0] need;
      logic [7:0] kb;
      if (rs) begin
        clear();
        return;
      end
      if (stuck) return;
      op = head0[3:0];
      case (st)
        ST_HEAD0: begin
          head0 = b;
          st = ST_HEAD1;
        end
        ST_HEAD1: begin
          len7 = b[6:0];
          // every check of the two fixed header bytes lands on the second byte
          if (!head0[7] || head0[6:4] != 3'b000 || !b[7] ||
              !(op inside {wscfd_pkg::OP_BINARY, wscfd_pkg::OP_CLOSE,
                           wscfd_pkg::OP_PING, wscfd_pkg::OP_PONG}) ||
              (op[3] && len7 > wscfd_pkg::LEN_SHORT_MAX)) begin
            latch_error();
          end else begin
            len_code = len7;
            len_acc  = '0;
            hdr_cnt  = '0;
            if (len7 <= wscfd_pkg::LEN_SHORT_MAX) begin
              if ({57'd0, len7} > {32'd0, max_len}) begin
                latch_error();
              end else begin
                remain = {57'd0, len7};
                key = '0;
                st = ST_KEY;
              end
            end else begin
              st = ST_LENGTH;
            end
          end
        end
        ST_LENGTH: begin
          len_acc = {len_acc[55:0], b};
          hdr_cnt = hdr_cnt + 3'd1;
          // eight length bytes wrap the 3-bit count back to zero
          need = (len_code == wscfd_pkg::LEN_CODE_16) ? 3'd2 : 3'd0;
          if (hdr_cnt == need) begin
            if ((len_code == wscfd_pkg::LEN_CODE_16) ? (len_acc < wscfd_pkg::LEN16_MIN)
                                                     : (len_acc <= 64'hFFFF)) begin
              latch_error();
            end else if (len_acc > {32'd0, max_len}) begin
              latch_error();
            end else begin
              remain  = len_acc;
              hdr_cnt = '0;
              key     = '0;
              st      = ST_KEY;
            end
          end
        end
        ST_KEY: begin
          key = {key[23:0], b};
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd4) begin
            hdr_cnt = '0;
            key_pos = '0;
            if (remain == '0) begin
              st = ST_HEAD0;
              push(wscfd_pkg::KIND_EMPTY, 8'h00, op, 1'b1);
            end else begin
              st = ST_DATA;
            end
          end
        end
        ST_DATA: begin
          kb = key[8 * (3 - key_pos) +: 8];
          key_pos = key_pos + 2'd1;
          remain = remain - 64'd1;
          if (remain == '0) st = ST_HEAD0;
          push(wscfd_pkg::KIND_PAYLOAD, b ^ kb, op, remain == '0);
        end
        default: clear();
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_word(wscfd_pkg::result_t got);
      wscfd_pkg::result_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected word kind %0d byte %02h op %0h last %0b",
                         got.kind, got.payload_byte, got.frame_opcode, got.last_of_frame));
        return;
      end
      want = decoded_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte %02h, want %02h", got.payload_byte, want.payload_byte));
      if (got.frame_opcode !== want.frame_opcode)
        report($sformatf("frame_opcode %0h, want %0h", got.frame_opcode, want.frame_opcode));
      if (got.last_of_frame !== want.last_of_frame)
        report($sformatf("last_of_frame %0b, want %0b", got.last_of_frame, want.last_of_frame));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  wscfd_in_if  in_if ();
  wscfd_out_if out_if ();

  websocket_client_frame_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  ws_frame_tracker tracker = new();

  logic [7:0]  frame_bytes[$];
  logic [3:0]  good_ops[4] = '{wscfd_pkg::OP_BINARY, wscfd_pkg::OP_CLOSE,
                               wscfd_pkg::OP_PING, wscfd_pkg::OP_PONG};
  logic [31:0] limits[6] = '{32'd0, 32'd200, 32'hFFFF_FFFF, 32'd130, 32'd65536,
                             wscfd_pkg::MAX_PAYLOAD_RESET};
  bit          idle_en;
  bit          hold_req;
  int unsigned n_words;

  always #5 clk_i = ~clk_i;

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 8);
        end
      end
      if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    wscfd_pkg::result_t r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      r.kind          = wscfd_pkg::kind_e'(out_if.kind);
      r.payload_byte  = out_if.payload_byte;
      r.frame_opcode  = out_if.frame_opcode;
      r.last_of_frame = out_if.last_of_frame;
      tracker.check_word(r);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offer one word and hold it until accepted; returns at a falling edge.
  task automatic put_word(input logic [7:0] b, input logic rs);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_if.data_byte = 8'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.restart   = rs;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_words++;
    tracker.note_word(b, rs);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic restart_parser();
    put_word(8'($urandom), 1'b1);
  endtask

  function automatic void build_frame(input logic [7:0] b0, input logic mbit,
                                      input logic [63:0] len, input len_form_e form,
                                      input bit body);
    logic [63:0] i;
    frame_bytes.delete();
    frame_bytes.push_back(b0);
    case (form)
      FORM_SHORT: frame_bytes.push_back({mbit, len[6:0]});
      FORM_16: begin
        frame_bytes.push_back({mbit, wscfd_pkg::LEN_CODE_16});
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
      end
      default: begin
        frame_bytes.push_back({mbit, LEN_CODE_64});
        for (int k = 7; k >= 0; k--) frame_bytes.push_back(len[8 * k +: 8]);
      end
    endcase
    if (body) begin
      repeat (4) frame_bytes.push_back(8'($urandom));
      for (i = 64'd0; i < len; i++) frame_bytes.push_back(8'($urandom));
    end
  endfunction

  // Send the first count bytes of the frame; once the parser is stuck, send three more, then drop the tail.
  task automatic send_bytes(input int unsigned count);
    int unsigned ignored;
    ignored = 0;
    for (int unsigned i = 0; i < count && i < frame_bytes.size(); i++) begin
      if (tracker.latched()) begin
        ignored++;
        if (ignored > 3) break;
      end
      put_word(frame_bytes[i], 1'b0);
    end
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tracker.set_limit(v);
  endtask

  task automatic settle();
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned n;
    logic [3:0]  op;
    logic [7:0]  b0;
    logic        mbit;
    logic [63:0] len;
    logic [31:0] hi;
    len_form_e   form;
    pick = $urandom_range(0, 99);
    op   = good_ops[$urandom_range(0, 3)];
    b0   = {1'b1, 3'b000, op};
    mbit = 1'b1;
    form = FORM_SHORT;
    len  = 64'($urandom_range(1, 12));
    if (pick < 70) begin
      n = $urandom_range(0, 9);
      if (n < 2) begin
        len = 64'd0;
      end else if (n == 7) begin
        len = 64'($urandom_range(100, 125));
      end else if (n >= 8 && op == wscfd_pkg::OP_BINARY) begin
        form = FORM_16;
        len  = 64'($urandom_range(126, 260));
      end
      build_frame(b0, mbit, len, form, 1'b1);
      send_bytes(32'hFFFF_FFFF);
    end else if (pick < 90) begin
      case ($urandom_range(0, 8))
        0: b0[7] = 1'b0;
        1: b0[6:4] = 3'($urandom_range(1, 7));
        2: mbit = 1'b0;
        3: begin
          do op = 4'($urandom);
          while (op == wscfd_pkg::OP_BINARY || op == wscfd_pkg::OP_CLOSE ||
                 op == wscfd_pkg::OP_PING || op == wscfd_pkg::OP_PONG);
          b0[3:0] = op;
        end
        4: begin
          b0[3:0] = good_ops[$urandom_range(1, 3)];
          form = ($urandom_range(0, 1) == 0) ? FORM_16 : FORM_64;
          len  = {$urandom, $urandom};
        end
        5: begin
          b0[3:0] = wscfd_pkg::OP_BINARY;
          form = FORM_16;
          len  = 64'($urandom_range(0, 125));
        end
        6: begin
          b0[3:0] = wscfd_pkg::OP_BINARY;
          form = FORM_64;
          len  = 64'($urandom_range(0, 65535));
        end
        7: begin
          // length beyond any 32-bit limit
          b0[3:0] = wscfd_pkg::OP_BINARY;
          form = FORM_64;
          hi   = $urandom_range(1, 32'hFFFF_FFFF);
          len  = {hi, 32'($urandom)};
        end
        default: begin
          // one past the configured limit, minimally encoded
          b0[3:0] = wscfd_pkg::OP_BINARY;
          len = {32'd0, tracker.max_len} + 64'd1;
          if (len <= 64'd125) form = FORM_SHORT;
          else if (len <= 64'hFFFF) form = FORM_16;
          else form = FORM_64;
        end
      endcase
      build_frame(b0, mbit, len, form, 1'b0);
      send_bytes(32'hFFFF_FFFF);
      repeat ($urandom_range(0, 3)) put_word(8'($urandom), 1'b0);
      restart_parser();
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 4)) put_word(8'($urandom), 1'b0);
      restart_parser();
    end else begin
      // cut a frame short anywhere before its last byte
      build_frame(b0, mbit, 64'd8, FORM_SHORT, 1'b1);
      send_bytes($urandom_range(1, 13));
      restart_parser();
    end
    if (tracker.latched()) restart_parser();
  endtask

  initial begin : stimulus
    int unsigned target;
    bit          pressed;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.restart    = 1'b0;
    idle_en          = 1'b1;
    hold_req         = 1'b0;
    n_words          = 0;
    pressed          = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_limit(wscfd_pkg::MAX_PAYLOAD_RESET);

    build_frame({1'b1, 3'b000, wscfd_pkg::OP_BINARY}, 1'b1, 64'd0, FORM_SHORT, 1'b1);
    send_bytes(32'hFFFF_FFFF);
    build_frame({1'b1, 3'b000, wscfd_pkg::OP_PONG}, 1'b1, 64'd2, FORM_SHORT, 1'b1);
    send_bytes(32'hFFFF_FFFF);
    // FIN clear, then a byte that must be ignored
    build_frame({1'b0, 3'b000, wscfd_pkg::OP_BINARY}, 1'b1, 64'd3, FORM_SHORT, 1'b0);
    send_bytes(32'hFFFF_FFFF);
    put_word(8'h55, 1'b0);
    restart_parser();
    // control frame with an extended length
    build_frame({1'b1, 3'b000, wscfd_pkg::OP_CLOSE}, 1'b1, 64'd200, FORM_16, 1'b0);
    send_bytes(32'hFFFF_FFFF);
    restart_parser();
    // text frame
    build_frame(8'h81, 1'b1, 64'd0, FORM_SHORT, 1'b0);
    send_bytes(32'hFFFF_FFFF);
    restart_parser();

    for (int p = 0; p < 6; p++) begin
      settle();
      write_limit(limits[p]);
      idle_en = (p != 5);
      if (limits[p] == 32'hFFFF_FFFF) begin
        // a real 64-bit length: header, key and a few payload bytes, then cut short
        build_frame({1'b1, 3'b000, wscfd_pkg::OP_BINARY}, 1'b1, 64'd65536, FORM_64, 1'b0);
        send_bytes(32'hFFFF_FFFF);
        repeat (10) put_word(8'($urandom), 1'b0);
        restart_parser();
      end
      target = n_words + 90;
      while (n_words < target) begin
        if (p == 1 && !pressed && n_words + 45 > target) begin
          hold_req = 1'b1;
          pressed  = 1'b1;
        end
        random_frame();
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- websocket_client_frame_decoder.f -----
hdl/wscfd_pkg.sv
hdl/wscfd_if.sv
hdl/wscfd_parser.sv
hdl/websocket_client_frame_decoder.sv
tb/tb_websocket_client_frame_decoder.sv
